// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset
`define BDLP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define BDLP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce package
// Sizes, register codes, event codes and the per-scan event record.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Sizes
  localparam int NUM_BUTTONS = 5;
  localparam int TIME_BITS   = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int ID_W        = $clog2(NUM_BUTTONS);
  localparam int SLOTS       = NUM_BUTTONS + 1;   // buttons, then the settings request
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IN_BITS     = NUM_BUTTONS + TIME_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = ID_W + 2 + TIME_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register reset values and timing constants
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] COMBO_HOLD_RESET = 16'd1000;
  localparam int LONG_WINDOW_MS = 100;

  // Button indexes used by the settings combo
  localparam int KEY_SELECT = 0;
  localparam int KEY_RIGHT  = 2;
  localparam int KEY_LEFT   = 3;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2,
    EV_SETTINGS = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_COMBO_HOLD = 2'd2
  } cfg_reg_t;

  // Events of one scan, at most one per button plus the settings request
  typedef struct packed {
    logic                                  settings;
    logic [NUM_BUTTONS-1:0]                valid;
    logic [NUM_BUTTONS-1:0][1:0]           kind;
    logic [NUM_BUTTONS-1:0][TIME_BITS-1:0] dur;
  } scan_rec_t;

endpackage

// ----- design/bdlp_queue.sv -----
// ----------------------------------------------------------------------------
// Scan record queue
// Short FIFO of per-scan event records between the classifier and emitter.
// ----------------------------------------------------------------------------
module bdlp_queue
  import bdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scan_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output scan_rec_t head_rec
);

  `include "assert_macros.svh"

  scan_rec_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BDLP_ASSERT_ALWAYS(a_count_bound, count <= (QPTR_W+1)'(QUEUE_DEPTH), "queue overfilled")
  `BDLP_ASSERT_IMPLY(a_no_pop_empty, pop, count != '0, "pop from empty queue")

endmodule

// ----- design/bdlp_front.sv -----
// ----------------------------------------------------------------------------
// Scan classifier
// Holds configuration and per-button state, debounces one scan per cycle
// while the queue has room and builds the record of events the scan causes.
// ----------------------------------------------------------------------------
module bdlp_front
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [NUM_BUTTONS-1:0] raw,
  input  logic [TIME_BITS-1:0]   now,
  output logic                   push,
  output scan_rec_t              push_rec,
  input  logic                   full
);

  `include "assert_macros.svh"

  localparam int CMP_W = TIME_BITS + 1;

  function automatic logic raw_bit(logic [NUM_BUTTONS-1:0] r, int idx);
    logic b;
    b = 1'b0;
    for (int k = 0; k < NUM_BUTTONS; k++) begin
      if (k == idx) b = r[k];
    end
    return b;
  endfunction

  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic [CFG_W-1:0] combo_hold_ms;

  logic [NUM_BUTTONS-1:0] debounced;
  logic [NUM_BUTTONS-1:0] long_reported;
  logic [TIME_BITS-1:0]   press_stamp   [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   release_stamp [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   combo_start;
  logic                   combo_timing;
  logic                   settings_requested;

  logic [NUM_BUTTONS-1:0] debounced_next;
  logic [NUM_BUTTONS-1:0] long_reported_next;
  logic [NUM_BUTTONS-1:0] set_press;
  logic [NUM_BUTTONS-1:0] set_release;
  logic                   combo_held;
  logic                   combo_fire;
  logic                   accept;
  scan_rec_t              rec;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && ((rec.valid != '0) || rec.settings);
  assign push_rec = rec;

  // Classify each button of the scan
  always_comb begin
    logic [TIME_BITS-1:0] ref_stamp;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] dur;
    logic                 chg;
    logic                 in_window;
    logic [TIME_BITS-1:0] combo_elapsed;
    rec                = '0;
    debounced_next     = debounced;
    long_reported_next = long_reported;
    set_press          = '0;
    set_release        = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      ref_stamp = debounced[i] ? press_stamp[i] : release_stamp[i];
      since     = now - ref_stamp;
      dur       = now - press_stamp[i];
      chg       = (raw[i] != debounced[i]) && (since >= TIME_BITS'(debounce_ms));
      in_window = (dur >= TIME_BITS'(long_press_ms)) &&
                  (CMP_W'(dur) < CMP_W'(long_press_ms) + CMP_W'(LONG_WINDOW_MS));
      rec.dur[i] = dur;
      if (chg && raw[i]) begin
        // accepted press
        debounced_next[i]     = 1'b1;
        long_reported_next[i] = 1'b0;
        set_press[i]          = 1'b1;
        rec.valid[i]          = 1'b1;
        rec.kind[i]           = EV_PRESSED;
        rec.dur[i]            = '0;
      end else if (chg) begin
        // accepted release
        debounced_next[i] = 1'b0;
        set_release[i]    = 1'b1;
        rec.valid[i]      = 1'b1;
        rec.kind[i]       = (dur >= TIME_BITS'(long_press_ms)) ? EV_LONG : EV_RELEASED;
      end else if (debounced[i] && in_window && !long_reported[i]) begin
        // held into the long-press window
        long_reported_next[i] = 1'b1;
        rec.valid[i]          = 1'b1;
        rec.kind[i]           = EV_LONG;
      end
    end
    combo_held    = raw_bit(raw, KEY_SELECT) && raw_bit(raw, KEY_RIGHT) &&
                    raw_bit(raw, KEY_LEFT);
    combo_elapsed = now - combo_start;
    combo_fire    = combo_held && combo_timing && !settings_requested &&
                    (combo_elapsed > TIME_BITS'(combo_hold_ms));
    rec.settings  = combo_fire;
  end

  // Hold configuration and per-button state
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= DEBOUNCE_RESET;
      long_press_ms      <= LONG_PRESS_RESET;
      combo_hold_ms      <= COMBO_HOLD_RESET;
      debounced          <= '0;
      long_reported      <= '0;
      combo_start        <= '0;
      combo_timing       <= 1'b0;
      settings_requested <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        press_stamp[i]   <= '0;
        release_stamp[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE:   debounce_ms   <= cfg_data;
          REG_LONG_PRESS: long_press_ms <= cfg_data;
          REG_COMBO_HOLD: combo_hold_ms <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        debounced     <= debounced_next;
        long_reported <= long_reported_next;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
          if (set_press[i])   press_stamp[i]   <= now;
          if (set_release[i]) release_stamp[i] <= now;
        end
        if (combo_held) begin
          if (!combo_timing) begin
            combo_timing <= 1'b1;
            combo_start  <= now;
          end else if (combo_fire) begin
            settings_requested <= 1'b1;
          end
        end else begin
          combo_timing       <= 1'b0;
          combo_start        <= '0;
          settings_requested <= 1'b0;
        end
      end
    end
  end

  `BDLP_ASSERT_IMPLY(a_settings_after_timing, $rose(settings_requested),
                     $past(combo_timing), "settings request without combo timing")

endmodule

// ----- design/bdlp_back.sv -----
// ----------------------------------------------------------------------------
// Event emitter
// Walks the head record of the queue and sends one event per transaction,
// buttons in index order, settings request last.
// ----------------------------------------------------------------------------
module bdlp_back
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  scan_rec_t            head_rec,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      out_id,
  output logic [1:0]           out_kind,
  output logic [TIME_BITS-1:0] out_dur,
  output logic                 out_last
);

  `include "assert_macros.svh"

  logic [SLOTS-1:0]  sent;
  logic [SLOTS-1:0]  rem;
  logic [SLOTS-1:0]  left;
  logic [SLOT_W-1:0] sel;
  logic              load;

  assign rem = {head_rec.settings, head_rec.valid} & ~sent;

  // Pick the lowest pending event
  always_comb begin
    sel = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (rem[k]) sel = SLOT_W'(k);
    end
  end

  assign left = rem & ~(SLOTS'(1) << sel);
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (left == '0);

  // Hold the output transaction and the emitted mask
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sent      <= pop ? '0 : (sent | (SLOTS'(1) << sel));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_last <= pop;
      if (sel == SLOT_W'(NUM_BUTTONS)) begin
        out_id   <= ID_W'(KEY_SELECT);
        out_kind <= EV_SETTINGS;
        out_dur  <= '0;
      end else begin
        out_id   <= sel[ID_W-1:0];
        out_kind <= head_rec.kind[sel[ID_W-1:0]];
        out_dur  <= head_rec.dur[sel[ID_W-1:0]];
      end
    end
  end

  `BDLP_ASSERT_IMPLY(a_head_has_pending, head_valid, rem != '0,
                     "queued record with nothing left to send")

endmodule

// ----- design/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// Button debounce and long-press detector
// Debounces scans of the button levels, reports presses, releases and long
// presses per button, and a settings request for a held three-button combo.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: raw_pressed, now_ms
//   m_axis    out        tdata: button_id, event_kind, duration_ms; tlast
//   cfg       in         write of debounce_ms, long_press_ms, combo_hold_ms
//
// A scan is accepted every cycle while the two-entry record queue has room;
// scans without events leave no record. Each event is sent as its own output
// transaction, so a scan with n events gives n transactions (up to 6).
// Reset is synchronous; it restores register defaults and clears all
// button state. Output stalls back up into the queue, then into s_axis.
// ----------------------------------------------------------------------------
module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // scans
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // raw_pressed, now_ms, zero pad
  // events
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // button_id, event_kind, duration_ms, zero pad
  output logic                   m_axis_tlast
);

  logic                 push;
  scan_rec_t            push_rec;
  logic                 full;
  logic                 pop;
  logic                 head_valid;
  scan_rec_t            head_rec;
  logic [ID_W-1:0]      out_id;
  logic [1:0]           out_kind;
  logic [TIME_BITS-1:0] out_dur;

  bdlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .raw       (s_axis_tdata[NUM_BUTTONS-1:0]),
    .now       (s_axis_tdata[NUM_BUTTONS +: TIME_BITS]),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full)
  );

  bdlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  bdlp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (out_id),
    .out_kind   (out_kind),
    .out_dur    (out_dur),
    .out_last   (m_axis_tlast)
  );

  // Pack the event fields, lowest field first
  assign m_axis_tdata = OUT_TDATA_W'({out_dur, out_kind, out_id});

endmodule
